### hw/rtl/rfae_pkg.sv
// Shared types and constants for the register file ALU execution unit.
package rfae_pkg;

   localparam int INSTR_W  = 32;
   localparam int DATA_W   = 32;
   localparam int REG_W    = 3;
   localparam int NUM_REGS = 8;
   localparam int OPC_LSB  = 28;
   localparam int OPC_W    = 4;
   localparam int RA_LSB   = 6;
   localparam int RB_LSB   = 3;
   localparam int RC_LSB   = 0;
   localparam int CNT_W    = 5;
   localparam int RSP_PAD  = 3;
   localparam int RSP_W    = 1 + REG_W + DATA_W + 1 + RSP_PAD;

   // Raw opcodes
   localparam logic [OPC_W-1:0] OPC_CMOV = 4'd0;
   localparam logic [OPC_W-1:0] OPC_ADD  = 4'd3;
   localparam logic [OPC_W-1:0] OPC_MUL  = 4'd4;
   localparam logic [OPC_W-1:0] OPC_DIV  = 4'd5;
   localparam logic [OPC_W-1:0] OPC_NAND = 4'd6;

   // Decoded operation kinds
   localparam logic [2:0] KIND_NOP  = 3'd0;
   localparam logic [2:0] KIND_CMOV = 3'd1;
   localparam logic [2:0] KIND_ADD  = 3'd2;
   localparam logic [2:0] KIND_MUL  = 3'd3;
   localparam logic [2:0] KIND_DIV  = 3'd4;
   localparam logic [2:0] KIND_NAND = 3'd5;

   typedef struct packed {
      logic [2:0]       kind;
      logic [REG_W-1:0] ra;
      logic [REG_W-1:0] rb;
      logic [REG_W-1:0] rc;
   } instr_type;

   typedef struct packed {
      logic              div_by_zero;
      logic [DATA_W-1:0] write_value;
      logic [REG_W-1:0]  dest_reg;
      logic              wrote;
   } result_type;

endpackage

### hw/rtl/rfae_front.sv
// Front end: accepts instruction beats, decodes them and queues them for execution.
module rfae_front import rfae_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [INSTR_W-1:0] req_tdata,   // instruction_word
   output logic               deq_valid,
   input  logic               deq_ready,
   output instr_type          deq_instr
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(QUEUE_DEPTH);

   instr_type         entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0] count_ff, count_in;
   instr_type         decoded;
   logic              push, pop;

   always_comb begin
      decoded.ra = req_tdata[RA_LSB +: REG_W];
      decoded.rb = req_tdata[RB_LSB +: REG_W];
      decoded.rc = req_tdata[RC_LSB +: REG_W];
      unique case (req_tdata[OPC_LSB +: OPC_W])
         OPC_CMOV: decoded.kind = KIND_CMOV;
         OPC_ADD:  decoded.kind = KIND_ADD;
         OPC_MUL:  decoded.kind = KIND_MUL;
         OPC_DIV:  decoded.kind = KIND_DIV;
         OPC_NAND: decoded.kind = KIND_NAND;
         default:  decoded.kind = KIND_NOP;
      endcase
   end

   assign req_tready = (count_ff != FULL_CNT);
   assign deq_valid  = (count_ff != '0);
   assign deq_instr  = entry_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = deq_valid && deq_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

### hw/rtl/rfae_back.sv
// Back end: register file, ALU, iterative divider and result register.
module rfae_back import rfae_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             deq_valid,
   output logic             deq_ready,
   input  instr_type        deq_instr,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata   // wrote, dest_reg[2:0], write_value[31:0], div_by_zero
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_EXEC = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]        state_ff, state_in;
   instr_type         instr_ff, instr_in;
   logic [DATA_W-1:0] rf_mem [NUM_REGS];
   logic [NUM_REGS-1:0] rf_valid_ff, rf_valid_in;
   logic [DATA_W-1:0] opb_ff, opc_ff;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   result_type        res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]  rsp_data_ff, rsp_data_in;
   logic              rf_we;
   logic              retire;
   logic [DATA_W:0]   shifted;
   logic              fits;
   logic [DATA_W-1:0] mul_lo;

   assign deq_ready  = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign shifted = {rem_ff, quo_ff[DATA_W-1]};
   assign fits    = (shifted >= {1'b0, opc_ff});
   assign mul_lo  = opb_ff * opc_ff;
   assign retire  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);
   assign rf_we   = retire && res_ff.wrote;

   always_comb begin
      state_in     = state_ff;
      instr_in     = instr_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      rf_valid_in  = rf_valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (deq_valid) begin
               instr_in = deq_instr;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            res_in.dest_reg    = instr_ff.ra;
            res_in.wrote       = 1'b0;
            res_in.write_value = '0;
            res_in.div_by_zero = 1'b0;
            state_in           = ST_DONE;
            unique case (instr_ff.kind)
               KIND_CMOV: begin
                  if (opc_ff != '0) begin
                     res_in.wrote       = 1'b1;
                     res_in.write_value = opb_ff;
                  end
               end
               KIND_ADD: begin
                  res_in.wrote       = 1'b1;
                  res_in.write_value = opb_ff + opc_ff;
               end
               KIND_MUL: begin
                  res_in.wrote       = 1'b1;
                  res_in.write_value = mul_lo;
               end
               KIND_NAND: begin
                  res_in.wrote       = 1'b1;
                  res_in.write_value = ~(opb_ff & opc_ff);
               end
               KIND_DIV: begin
                  if (opc_ff == '0) begin
                     res_in.div_by_zero = 1'b1;
                  end else begin
                     rem_in   = '0;
                     quo_in   = opb_ff;
                     cnt_in   = '1;
                     state_in = ST_DIV;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_DIV: begin
            // restoring divide, one quotient bit per cycle
            rem_in = fits ? DATA_W'(shifted - {1'b0, opc_ff}) : shifted[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], fits};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               res_in.wrote       = 1'b1;
               res_in.write_value = {quo_ff[DATA_W-2:0], fits};
               state_in           = ST_DONE;
            end
         end
         ST_DONE: begin
            if (retire) begin
               if (res_ff.wrote) begin
                  rf_valid_in[res_ff.dest_reg] = 1'b1;
               end
               rsp_valid_in = 1'b1;
               rsp_data_in  = {RSP_PAD'(0), res_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rf_valid_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rf_valid_ff  <= rf_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      instr_ff    <= instr_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // register file: two registered reads, one write
   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         opb_ff <= rf_valid_ff[instr_ff.rb] ? rf_mem[instr_ff.rb] : '0;
         opc_ff <= rf_valid_ff[instr_ff.rc] ? rf_mem[instr_ff.rc] : '0;
      end
      if (rf_we) begin
         rf_mem[res_ff.dest_reg] <= res_ff.write_value;
      end
   end

endmodule

### hw/rtl/register_file_alu_exec_unit.sv
// Top level of the register file ALU execution unit.
// Executes one 32-bit instruction per input beat against eight 32-bit registers
// (cleared by reset) and returns exactly one result beat per instruction, in order.
// Instructions are decoded into a small queue, so the input keeps accepting while
// the execution side works. Execution handles one instruction at a time: move, add,
// multiply, NAND and unknown opcodes go through queue pop, register read, ALU and
// retire; divide runs the bit-serial restoring divider, one quotient bit per cycle,
// before retire. A zero divisor skips the divider and retires with div_by_zero set.
module register_file_alu_exec_unit import rfae_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [INSTR_W-1:0] req_tdata,   // instruction_word[31:0]
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [RSP_W-1:0]   rsp_tdata    // wrote, dest_reg[2:0], write_value[31:0],
                                           // div_by_zero, zero pad
);

   logic      deq_valid;
   logic      deq_ready;
   instr_type deq_instr;

   rfae_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .deq_valid  (deq_valid),
      .deq_ready  (deq_ready),
      .deq_instr  (deq_instr)
   );

   rfae_back u_back (
      .clock      (clock),
      .reset      (reset),
      .deq_valid  (deq_valid),
      .deq_ready  (deq_ready),
      .deq_instr  (deq_instr),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef SYNTHESIS
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (req_tready && !rsp_tvalid))
      else $error("queue or result register not cleared by reset");

   a_idle_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[0]) |-> (rsp_tdata[DATA_W+REG_W:REG_W+1] == '0))
      else $error("write_value nonzero on a beat that wrote nothing");

   a_dz_no_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[DATA_W+REG_W+1]) |-> !rsp_tdata[0])
      else $error("divide by zero beat reports a register write");

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      (deq_ready && deq_valid) |=> !deq_ready)
      else $error("execution side popped without starting");
`endif

endmodule

### sim/result_checker.sv
// Checker for the register file ALU execution unit: predicts each result beat and compares.
module result_checker import rfae_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tready,
   input  logic [INSTR_W-1:0] req_tdata,
   input  logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  logic [RSP_W-1:0]   rsp_tdata,
   output int                 mismatch_count,
   output int                 outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [DATA_W-1:0] arch_regs [NUM_REGS];
   result_type        pending_results [$];

   // Operands are read before the write, so A may alias B or C.
   task automatic execute_instruction(input logic [INSTR_W-1:0] word, output result_type res);
      logic [OPC_W-1:0]  op;
      logic [REG_W-1:0]  ia;
      logic [DATA_W-1:0] vb;
      logic [DATA_W-1:0] vc;
      op = word[OPC_LSB +: OPC_W];
      ia = word[RA_LSB +: REG_W];
      vb = arch_regs[word[RB_LSB +: REG_W]];
      vc = arch_regs[word[RC_LSB +: REG_W]];
      res = '0;
      res.dest_reg = ia;
      case (op)
         OPC_CMOV: begin
            if (vc != '0) begin
               res.write_value = vb;
               res.wrote = 1'b1;
            end
         end
         OPC_ADD: begin
            res.write_value = vb + vc;
            res.wrote = 1'b1;
         end
         OPC_MUL: begin
            res.write_value = vb * vc;
            res.wrote = 1'b1;
         end
         OPC_DIV: begin
            if (vc == '0) begin
               res.div_by_zero = 1'b1;
            end else begin
               res.write_value = vb / vc;
               res.wrote = 1'b1;
            end
         end
         OPC_NAND: begin
            res.write_value = ~(vb & vc);
            res.wrote = 1'b1;
         end
         default: ;
      endcase
      if (res.wrote)
         arch_regs[ia] = res.write_value;
   endtask

   always @(posedge clock) begin : monitor
      result_type want;
      result_type got;
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++)
            arch_regs[i] = '0;
         pending_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[RSP_W-RSP_PAD-1:0]);
            if (pending_results.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: unexpected result beat: wrote=%0d dest=%0d value=%h dz=%0d",
                           $realtime, got.wrote, got.dest_reg, got.write_value, got.div_by_zero);
               mismatch_count++;
            end else begin
               want = pending_results.pop_front();
               if (got.wrote !== want.wrote || got.dest_reg !== want.dest_reg ||
                   got.write_value !== want.write_value ||
                   got.div_by_zero !== want.div_by_zero) begin
                  if (mismatch_count < 10)
                     $display({"%0t: result mismatch: expected wrote=%0d dest=%0d value=%h ",
                               "dz=%0d, got wrote=%0d dest=%0d value=%h dz=%0d"},
                              $realtime, want.wrote, want.dest_reg, want.write_value,
                              want.div_by_zero, got.wrote, got.dest_reg, got.write_value,
                              got.div_by_zero);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            execute_instruction(req_tdata, want);
            pending_results.push_back(want);
         end
      end
      outstanding = pending_results.size();
   end

endmodule

### sim/testbench.sv
// Top of the testbench: clock, reset, instruction and backpressure stimulus, and the verdict.
module testbench;
   import rfae_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1130;
   localparam int QUIET_ITEMS  = 150;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 60;

   logic               clock;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   logic [INSTR_W-1:0] req_tdata;
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [RSP_W-1:0]   rsp_tdata;
   int                 mismatch_count;
   int                 outstanding;
   int                 idle_cycles;
   logic               quiet;

   register_file_alu_exec_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   result_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic implemented_op(input logic [OPC_W-1:0] op);
      implemented_op = (op == OPC_CMOV) || (op == OPC_ADD) || (op == OPC_MUL) ||
                       (op == OPC_DIV) || (op == OPC_NAND);
   endfunction

   // Unused bits 27:9 get random filler.
   function automatic logic [INSTR_W-1:0] encode(input logic [OPC_W-1:0] op,
                                                 input logic [REG_W-1:0] a,
                                                 input logic [REG_W-1:0] b,
                                                 input logic [REG_W-1:0] c);
      logic [31:0] junk;
      junk = $urandom;
      encode = {op, junk[18:0], a, b, c};
   endfunction

   task automatic send_instruction(input logic [INSTR_W-1:0] word);
      int gap;
      @(negedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
   endtask

   // Result-side backpressure in bursts.
   initial begin
      int stall;
      stall = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            stall = $urandom_range(1, 7) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("[register_file_alu_exec_unit] ERROR");
            $finish;
         end
      end
   end

   initial begin
      int               pick;
      logic [OPC_W-1:0] op;
      logic [REG_W-1:0] ra;
      logic [REG_W-1:0] rb;
      logic [REG_W-1:0] rc;
      quiet      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: all-zero word is a move with a false condition
      send_instruction('0);
      send_instruction(encode(OPC_CMOV, 3'd1, 3'd0, 3'd2));
      send_instruction(encode(OPC_NAND, 3'd0, 3'd0, 3'd0));
      send_instruction(encode(OPC_CMOV, 3'd1, 3'd0, 3'd0));
      send_instruction(encode(OPC_ADD,  3'd2, 3'd0, 3'd1));
      send_instruction(encode(OPC_MUL,  3'd3, 3'd0, 3'd2));
      send_instruction(encode(OPC_DIV,  3'd4, 3'd0, 3'd3));
      send_instruction(encode(OPC_DIV,  3'd5, 3'd0, 3'd5));
      send_instruction(encode(OPC_DIV,  3'd6, 3'd0, 3'd0));
      send_instruction(encode(OPC_ADD,  3'd3, 3'd3, 3'd3));
      send_instruction(encode(OPC_NAND, 3'd7, 3'd7, 3'd7));
      send_instruction(encode(OPC_CMOV, 3'd5, 3'd4, 3'd7));
      send_instruction(encode(OPC_MUL,  3'd2, 3'd2, 3'd2));
      for (int k = 0; k < 16; k++)
         if (!implemented_op(OPC_W'(k)))
            send_instruction(encode(OPC_W'(k), 3'($urandom_range(0, 7)),
                                    3'($urandom_range(0, 7)), 3'($urandom_range(0, 7))));
      send_instruction('1);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i >= RANDOM_ITEMS - QUIET_ITEMS)
            quiet = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 15)
            op = OPC_CMOV;
         else if (pick < 30)
            op = OPC_ADD;
         else if (pick < 45)
            op = OPC_MUL;
         else if (pick < 65)
            op = OPC_DIV;
         else if (pick < 88)
            op = OPC_NAND;
         else begin
            do op = OPC_W'($urandom); while (implemented_op(op));
         end
         ra = 3'($urandom_range(0, 7));
         rb = 3'($urandom_range(0, 7));
         rc = 3'($urandom_range(0, 7));
         send_instruction(encode(op, ra, rb, rc));
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0)
         $display("[register_file_alu_exec_unit] OK");
      else
         $display("[register_file_alu_exec_unit] ERROR");
      $finish;
   end

endmodule

### files.f
hw/rtl/rfae_pkg.sv
hw/rtl/rfae_front.sv
hw/rtl/rfae_back.sv
hw/rtl/register_file_alu_exec_unit.sv
sim/result_checker.sv
sim/testbench.sv
